@@ rtl/core/text_console_writer_macros.svh @@
// Assertion macros used by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcw assertion failed");

// Next-cycle implication, checked out of reset.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

@@ rtl/core/tcw_pkg.sv @@
// Package with the types, constants and helpers of the text console writer.
`timescale 1ns / 1ps
package tcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int LAST_START    = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;
    localparam int ADDR_W        = $clog2(CELL_COUNT);
    localparam int ROW_W         = 5;
    localparam int COL_W         = 7;
    localparam int CELL_W        = 16;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'h20;
    localparam logic [7:0] DEFAULT_ATTR = 8'h0F;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PUT   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_column;
    } t_in_word;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              scrolled;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_SCR_RD,
        S_SCR_WR,
        S_BLANK,
        S_READ
    } t_state;

    // Linear cell address of a row and column; the constant multiply is shift-add.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
    endfunction

endpackage

@@ rtl/core/text_console_writer.sv @@
// Top level of the text console writer: sequencer, cursor and configuration.
`timescale 1ns / 1ps
// A command is taken at a clock edge where start is high and busy is low; the
// word on i_in holds the operation (clear, put, read), the character and the
// cell to read. Each command gives exactly one result word on o_out, shown for
// one cycle with o_valid high; the receiver cannot hold it off.
// i_cfg_we writes the color attribute from i_cfg_wdata; do so while idle.
// Steps to the result strobe: put in S_EXEC; read in S_EXEC, S_READ; clear in
// S_EXEC, S_FILL (one cell per cycle through the single memory write port).
// A put that passes the last row scrolls: each of the 1920 moved cells is read
// in S_SCR_RD and written in S_SCR_WR, then S_BLANK blanks the 80 cells of the
// bottom line. busy stays high through the work.
// After reset a clearing pass writes blanks, white on black, into every cell;
// busy is high meanwhile and configuration writes are taken.
// Reset homes the cursor and sets the attribute to white on black.
// The result register frees the command side, so a new command may be taken
// in the very cycle a result is strobed.
module text_console_writer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  tcw_pkg::t_in_word    i_in,
    output logic                 o_valid,
    output tcw_pkg::t_out_word   o_out,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata
);
    import tcw_pkg::*;

    `include "text_console_writer_macros.svh"

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    t_out_word         r_out, n_out;
    logic              r_valid, n_valid;
    t_in_word          r_in;
    logic [7:0]        r_color;

    t_mem_req          mem_req;
    logic [CELL_W-1:0] mem_rdata;
    logic [ROW_W-1:0]  a_row;
    logic [COL_W-1:0]  a_col;
    logic [ADDR_W-1:0] a_addr;
    logic              rd_in_range;

    tcw_screen_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // The one address unit serves both the read cell and the cursor cell.
    assign a_row  = (r_in.operation == OP_READ) ? r_in.read_row : r_row;
    assign a_col  = (r_in.operation == OP_READ) ? r_in.read_column : r_col;
    assign a_addr = cell_addr(a_row, a_col);

    assign rd_in_range = (r_in.read_row < ROW_W'(SCREEN_HEIGHT)) &&
                         (r_in.read_column < COL_W'(SCREEN_WIDTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_valid <= 1'b0;
            r_color <= DEFAULT_ATTR;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_row   <= n_row;
            r_col   <= n_col;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (start && !busy) begin
            r_in <= i_in;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_row   = r_row;
        n_col   = r_col;
        n_out   = r_out;
        n_valid = 1'b0;

        mem_req       = '0;
        mem_req.raddr = r_ptr;

        case (r_state)
            S_INIT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_ptr;
                mem_req.wdata = {DEFAULT_ATTR, BLANK_CODE};
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out               = '0;
                n_out.cursor_row    = r_row;
                n_out.cursor_column = r_col;
                case (r_in.operation)
                    OP_CLEAR: begin
                        n_ptr   = '0;
                        n_state = S_FILL;
                    end
                    OP_PUT: begin
                        if (r_in.char_code != NEWLINE_CODE) begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = a_addr;
                            mem_req.wdata = {r_color, r_in.char_code};
                        end
                        if ((r_in.char_code != NEWLINE_CODE) &&
                            (r_col != COL_W'(SCREEN_WIDTH - 1))) begin
                            n_col               = r_col + 1'b1;
                            n_out.cursor_column = n_col;
                            n_valid             = 1'b1;
                            n_state             = S_IDLE;
                        end else begin
                            n_col               = '0;
                            n_out.cursor_column = '0;
                            if (r_row == ROW_W'(SCREEN_HEIGHT - 1)) begin
                                n_ptr   = '0;
                                n_state = S_SCR_RD;
                            end else begin
                                n_row            = r_row + 1'b1;
                                n_out.cursor_row = n_row;
                                n_valid          = 1'b1;
                                n_state          = S_IDLE;
                            end
                        end
                    end
                    OP_READ: begin
                        mem_req.raddr = a_addr;
                        n_state       = S_READ;
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                n_out.cell_value = rd_in_range ? mem_rdata : '0;
                n_valid          = 1'b1;
                n_state          = S_IDLE;
            end
            S_FILL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_ptr;
                mem_req.wdata = {r_color, BLANK_CODE};
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_ptr               = '0;
                    n_row               = '0;
                    n_col               = '0;
                    n_out.cursor_row    = '0;
                    n_out.cursor_column = '0;
                    n_valid             = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_SCR_RD: begin
                mem_req.raddr = r_ptr + ADDR_W'(SCREEN_WIDTH);
                n_state       = S_SCR_WR;
            end
            S_SCR_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_ptr;
                mem_req.wdata = mem_rdata;
                n_ptr         = r_ptr + 1'b1;
                if (r_ptr == ADDR_W'(LAST_START - 1)) begin
                    n_state = S_BLANK;
                end else begin
                    n_state = S_SCR_RD;
                end
            end
            S_BLANK: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_ptr;
                mem_req.wdata = {r_color, BLANK_CODE};
                if (r_ptr == ADDR_W'(CELL_COUNT - 1)) begin
                    n_ptr          = '0;
                    n_out.scrolled = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    `TCW_ASSERT_NOW(a_strobe_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `TCW_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    `TCW_ASSERT_NOW(a_cursor_on_screen, i_clk, i_rst_n, o_valid,
        (o_out.cursor_row < ROW_W'(SCREEN_HEIGHT)) &&
        (o_out.cursor_column < COL_W'(SCREEN_WIDTH)))
    `TCW_ASSERT_NOW(a_scroll_cursor_home, i_clk, i_rst_n, o_valid && o_out.scrolled,
        (o_out.cursor_row == ROW_W'(SCREEN_HEIGHT - 1)) && (o_out.cursor_column == '0))

endmodule

@@ rtl/core/tcw_screen_mem.sv @@
// Screen cell memory: one write port and one registered read port.
`timescale 1ns / 1ps
module tcw_screen_mem (
    input  logic                      i_clk,
    input  tcw_pkg::t_mem_req         i_req,
    output logic [tcw_pkg::CELL_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule
